// ===== design/rcc_pkg.sv =====
// Shared types, constants and the step expectation lookup for the rail calibration checker.
`timescale 1ns / 1ps
`default_nettype none

package rcc_pkg;

    localparam int MAX_STEPS         = 32;
    localparam int IDX_W             = $clog2(MAX_STEPS);
    localparam int STEP_W            = IDX_W + 1;
    localparam int FIRST_GROUP_SIZE  = 16;
    localparam int SECOND_GROUP_SIZE = 8;
    localparam int SAMPLE_W          = 16;
    localparam int SUM_W             = 21;
    localparam int CNT_W             = 6;
    localparam int STEP_IDX_W        = 5;
    localparam int DIV_CNT_W         = $clog2(SUM_W);
    localparam int CFG_ADDR_W        = 2;
    localparam int IN_TDATA_W        = 16;
    localparam int OUT_TDATA_W       = 40;

    typedef enum logic [1:0] {
        EXP_NONE,
        EXP_HIGH,
        EXP_LOW,
        EXP_MID
    } t_expect;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_TIE_SPREAD,
        CFG_RAIL_FLOOR,
        CFG_RAIL_MARGIN,
        CFG_MID_MARGIN
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_ACC,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_CALC,
        ST_READ,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic in_ready;
        logic div_start;
        logic calc;
        logic out_load;
        logic idx_inc;
        logic clear;
    } t_cmd;

    typedef struct packed {
        logic in_fire;
        logic in_last;
        logic div_done;
        logic emit_last;
        logic out_free;
    } t_stat;

    localparam t_expect FIRST_TABLE [FIRST_GROUP_SIZE] = '{
        EXP_NONE, EXP_HIGH, EXP_NONE, EXP_LOW,
        EXP_NONE, EXP_HIGH, EXP_NONE, EXP_LOW,
        EXP_MID,  EXP_MID,  EXP_LOW,  EXP_LOW,
        EXP_LOW,  EXP_LOW,  EXP_LOW,  EXP_LOW
    };

    localparam t_expect SECOND_TABLE [SECOND_GROUP_SIZE] = '{
        EXP_NONE, EXP_HIGH, EXP_NONE, EXP_LOW,
        EXP_NONE, EXP_HIGH, EXP_MID,  EXP_LOW
    };

    function automatic t_expect expect_of(input logic [STEP_W-1:0] step);
        t_expect e;
        if (step < STEP_W'(FIRST_GROUP_SIZE)) begin
            e = FIRST_TABLE[step[3:0]];
        end else if (step < STEP_W'(FIRST_GROUP_SIZE + SECOND_GROUP_SIZE)) begin
            e = SECOND_TABLE[step[2:0]];
        end else begin
            e = EXP_NONE;
        end
        return e;
    endfunction

endpackage

`default_nettype wire

// ===== design/rcc_div.sv =====
// Restoring divider, one quotient bit per cycle: rail sum over reading count.
`timescale 1ns / 1ps
`default_nettype none

module rcc_div
    import rcc_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [SUM_W-1:0] i_dividend,
    input  wire logic [CNT_W-1:0] i_divisor,
    output logic                  o_done,
    output logic      [SUM_W-1:0] o_quotient
);

    logic                 r_busy, n_busy;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic [SUM_W-1:0]     r_quo, n_quo;
    logic [CNT_W-1:0]     r_rem, n_rem;
    logic [CNT_W-1:0]     r_div, n_div;
    logic [CNT_W:0]       trial;
    logic                 ge;

    always_comb begin
        trial  = {r_rem, r_quo[SUM_W-1]};
        ge     = trial >= {1'b0, r_div};
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_div  = r_div;
        o_done = r_busy && (r_cnt == DIV_CNT_W'(SUM_W - 1));
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_quo  = i_dividend;
            n_rem  = '0;
            n_div  = i_divisor;
        end else if (r_busy) begin
            n_quo = {r_quo[SUM_W-2:0], ge};
            n_rem = ge ? CNT_W'(trial - {1'b0, r_div}) : trial[CNT_W-1:0];
            n_cnt = r_cnt + 1'b1;
            if (o_done) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_div <= n_div;
    end

    assign o_quotient = r_quo;

endmodule

`default_nettype wire

// ===== design/rcc_datapath.sv =====
// Datapath: config registers, reading store, rail statistics, level division and verdicts.
`timescale 1ns / 1ps
`default_nettype none

module rcc_datapath
    import rcc_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_cmd                   i_cmd,
    output t_stat                       o_stat,
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_ADDR_W-1:0]  i_cfg_addr,
    input  wire logic [SAMPLE_W-1:0]    i_cfg_data,
    input  wire logic                   i_in_valid,
    input  wire logic [SAMPLE_W-1:0]    i_sample,
    input  wire logic                   i_final_step,
    input  wire logic                   i_out_ready,
    output logic                        o_out_valid,
    output logic [OUT_TDATA_W-1:0]      o_out_data,
    output logic                        o_out_last
);

    logic [SAMPLE_W-1:0] r_tie_spread, r_rail_floor, r_rail_margin, r_mid_margin;

    logic [SAMPLE_W-1:0] r_mem [MAX_STEPS];
    logic [SAMPLE_W-1:0] r_rd_data;

    logic [STEP_W-1:0]   r_step_count;
    logic [SUM_W-1:0]    r_high_sum, r_low_sum;
    logic [CNT_W-1:0]    r_high_count, r_low_count;
    logic [SAMPLE_W-1:0] r_high_min, r_high_max, r_low_min, r_low_max;
    logic [IDX_W-1:0]    r_idx;

    logic [SAMPLE_W-1:0] r_zero, r_rail;
    logic                r_valid;

    logic                r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;
    logic                r_out_last;

    logic                in_fire, store_en;
    t_expect             acc_exp, emit_exp;
    logic                low_done, high_done;
    logic [SUM_W-1:0]    low_quo, high_quo;
    logic                have_both;
    logic [SAMPLE_W-1:0] n_zero, n_rail;
    logic                n_valid;
    logic [SAMPLE_W:0]   x_plus_rm, z_plus_rm, x_plus_mm, mid_plus_mm;
    logic [SAMPLE_W:0]   level_sum;
    logic [SAMPLE_W-1:0] mid;
    logic                pass;
    logic                emit_last;

    assign in_fire  = i_in_valid && i_cmd.in_ready;
    assign store_en = in_fire && (r_step_count < STEP_W'(MAX_STEPS));
    assign acc_exp  = expect_of(r_step_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tie_spread  <= 16'd64;
            r_rail_floor  <= 16'd60000;
            r_rail_margin <= 16'd512;
            r_mid_margin  <= 16'd2048;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_TIE_SPREAD:  r_tie_spread  <= i_cfg_data;
                CFG_RAIL_FLOOR:  r_rail_floor  <= i_cfg_data;
                CFG_RAIL_MARGIN: r_rail_margin <= i_cfg_data;
                CFG_MID_MARGIN:  r_mid_margin  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (store_en) begin
            r_mem[r_step_count[IDX_W-1:0]] <= i_sample;
        end
        r_rd_data <= r_mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_step_count <= '0;
            r_high_sum   <= '0;
            r_low_sum    <= '0;
            r_high_count <= '0;
            r_low_count  <= '0;
            r_high_min   <= '1;
            r_high_max   <= '0;
            r_low_min    <= '1;
            r_low_max    <= '0;
            r_idx        <= '0;
        end else begin
            if (store_en) begin
                r_step_count <= r_step_count + 1'b1;
                if (acc_exp == EXP_HIGH) begin
                    r_high_sum   <= r_high_sum + SUM_W'(i_sample);
                    r_high_count <= r_high_count + 1'b1;
                    if (i_sample < r_high_min) r_high_min <= i_sample;
                    if (i_sample > r_high_max) r_high_max <= i_sample;
                end else if (acc_exp == EXP_LOW) begin
                    r_low_sum   <= r_low_sum + SUM_W'(i_sample);
                    r_low_count <= r_low_count + 1'b1;
                    if (i_sample < r_low_min) r_low_min <= i_sample;
                    if (i_sample > r_low_max) r_low_max <= i_sample;
                end
            end
            if (i_cmd.idx_inc) begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    rcc_div u_low_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_low_sum),
        .i_divisor  (r_low_count),
        .o_done     (low_done),
        .o_quotient (low_quo)
    );

    rcc_div u_high_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_high_sum),
        .i_divisor  (r_high_count),
        .o_done     (high_done),
        .o_quotient (high_quo)
    );

    // levels and span validity, registered once per scan
    always_comb begin
        have_both = (r_high_count != '0) && (r_low_count != '0);
        n_zero    = have_both ? low_quo[SAMPLE_W-1:0]  : '0;
        n_rail    = have_both ? high_quo[SAMPLE_W-1:0] : '0;
        n_valid   = have_both
                 && ((r_high_max - r_high_min) <= r_tie_spread)
                 && ((r_low_max - r_low_min) <= r_tie_spread)
                 && (n_rail >= r_rail_floor)
                 && (n_zero <= r_rail_margin)
                 && (n_rail > n_zero);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.calc) begin
            r_zero  <= n_zero;
            r_rail  <= n_rail;
            r_valid <= n_valid;
        end
    end

    // per-step verdict; comparisons rearranged to stay unsigned
    always_comb begin
        emit_exp    = expect_of({1'b0, r_idx});
        level_sum   = {1'b0, r_zero} + {1'b0, r_rail};
        mid         = level_sum[SAMPLE_W:1];
        x_plus_rm   = {1'b0, r_rd_data} + {1'b0, r_rail_margin};
        z_plus_rm   = {1'b0, r_zero} + {1'b0, r_rail_margin};
        x_plus_mm   = {1'b0, r_rd_data} + {1'b0, r_mid_margin};
        mid_plus_mm = {1'b0, mid} + {1'b0, r_mid_margin};
        case (emit_exp)
            EXP_NONE: pass = 1'b1;
            EXP_LOW:  pass = r_valid && ({1'b0, r_rd_data} <= z_plus_rm);
            EXP_HIGH: pass = r_valid && (x_plus_rm >= {1'b0, r_rail});
            default:  pass = r_valid && (x_plus_mm >= {1'b0, mid})
                          && ({1'b0, r_rd_data} <= mid_plus_mm);
        endcase
        emit_last = (STEP_W'(r_idx) + 1'b1) == r_step_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.out_load) begin
            r_out_data <= {1'b0, r_valid, r_rail, r_zero, pass, STEP_IDX_W'(r_idx)};
            r_out_last <= emit_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_out_last  = r_out_last;

    assign o_stat.in_fire   = in_fire;
    assign o_stat.in_last   = i_final_step;
    assign o_stat.div_done  = low_done && high_done;
    assign o_stat.emit_last = emit_last;
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

endmodule

`default_nettype wire

// ===== design/rcc_ctrl.sv =====
// Controller: sequences accumulation, level division, validity check and verdict output.
`timescale 1ns / 1ps
`default_nettype none

module rcc_ctrl
    import rcc_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd,
    output t_state     o_state
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_ACC;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_ACC: begin
                o_cmd.in_ready = 1'b1;
                if (i_stat.in_fire && i_stat.in_last) begin
                    n_state = ST_DIV_GO;
                end
            end
            ST_DIV_GO: begin
                o_cmd.div_start = 1'b1;
                n_state         = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (i_stat.div_done) begin
                    n_state = ST_CALC;
                end
            end
            ST_CALC: begin
                o_cmd.calc = 1'b1;
                n_state    = ST_READ;
            end
            ST_READ: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    if (i_stat.emit_last) begin
                        o_cmd.clear = 1'b1;
                        n_state     = ST_ACC;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                        n_state       = ST_READ;
                    end
                end
            end
            default: n_state = ST_ACC;
        endcase
    end

    assign o_state = r_state;

endmodule

`default_nettype wire

// ===== design/rail_calibration_checker.sv =====
// Top level of the rail calibration checker: stream ports, controller and datapath.
// Readings: one word per cycle while a scan is collected.
// The first verdict word follows the final reading through the start state, a bit-serial
// divide of each rail sum, the validity check, a store read and the output register.
// Each further verdict waits for a registered store read of its step and for a free output word.
// Reset (synchronous, active low) returns registers to defaults and clears the scan.
`timescale 1ns / 1ps
`default_nettype none

module rail_calibration_checker
    import rcc_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_ADDR_W-1:0]  i_cfg_addr,
    input  wire logic [SAMPLE_W-1:0]    i_cfg_data,
    input  wire logic                   i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]  i_s_axis_tdata,  // [15:0] sample
    input  wire logic                   i_s_axis_tlast,  // final_step
    output logic                        o_m_axis_tvalid,
    input  wire logic                   i_m_axis_tready,
    // [4:0] step_index, [5] pass, [21:6] zero_level, [37:22] rail_level,
    // [38] span_valid, [39] zero
    output logic [OUT_TDATA_W-1:0]      o_m_axis_tdata,
    output logic                        o_m_axis_tlast   // last_result
);

    t_cmd   cmd;
    t_stat  stat;
    t_state state;

    rcc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_state (state)
    );

    rcc_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_s_axis_tvalid),
        .i_sample     (i_s_axis_tdata[SAMPLE_W-1:0]),
        .i_final_step (i_s_axis_tlast),
        .i_out_ready  (i_m_axis_tready),
        .o_out_valid  (o_m_axis_tvalid),
        .o_out_data   (o_m_axis_tdata),
        .o_out_last   (o_m_axis_tlast)
    );

    assign o_s_axis_tready = cmd.in_ready;

`ifndef SYNTHESIS
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> stat.out_free)
        else $error("verdict loaded over a pending word");

    a_no_input_after_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_s_axis_tready && i_s_axis_tvalid && i_s_axis_tlast) |=>
        (!o_s_axis_tready && state == ST_DIV_GO))
        else $error("input taken after final reading");

    a_clear_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.clear |-> (cmd.out_load && stat.emit_last))
        else $error("scan cleared before last verdict");
`endif

endmodule

`default_nettype wire
